// File: rtl/ghfna_pkg.sv
// ----------------------------------------------------------------------------
// ghfna_pkg
// Shared types, constants and helpers of the grid hole fill block.
// ----------------------------------------------------------------------------
`default_nettype none

package ghfna_pkg;

  localparam int GRID_COLS_DEF   = 36;
  localparam int GRID_ROWS_DEF   = 32;
  localparam int NUM_MODULES_DEF = 32;
  localparam int VALUE_BITS_DEF  = 24;

  localparam int OUT_BITS   = 24;
  localparam int COUNT_BITS = 12;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // neighbour count 0..4, also the divisor width
  localparam int DIV_BITS = 3;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_FILL  = 2'd1,
    REQ_READ  = 2'd2
  } req_type_t;

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + (COUNT_BITS + 1)'(b);
    return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[COUNT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/ghfna_ram.sv
// ----------------------------------------------------------------------------
// ghfna_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ghfna_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/ghfna_div.sv
// ----------------------------------------------------------------------------
// ghfna_div
// Two-lane average by a neighbour count of one to four, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ghfna_div #(
  parameter int SUM_W = 26
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [SUM_W-1:0]               num_a,
  input  wire logic [ghfna_pkg::DIV_BITS-1:0] den_a,
  input  wire logic [SUM_W-1:0]               num_b,
  input  wire logic [ghfna_pkg::DIV_BITS-1:0] den_b,
  output logic                                done,
  output logic      [SUM_W-1:0]               quot_a,
  output logic      [SUM_W-1:0]               quot_b
);

  localparam int DB = ghfna_pkg::DIV_BITS;
  localparam int K  = SUM_W + 1;
  localparam int PW = SUM_W + K;
  // ceil(2^K / 3): exact floor(s / 3) for every s below 2^SUM_W
  localparam logic [K-1:0] THIRD = K'(((longint'(1) << K) + 2) / 3);

  function automatic logic [SUM_W-1:0] avg(input logic [SUM_W-1:0] s,
                                           input logic [DB-1:0]    d);
    logic [PW-1:0]    p;
    logic [SUM_W-1:0] q;
    p = PW'(s) * PW'(THIRD);
    q = '0;
    unique case (d)
      DB'(1): q = s;
      DB'(2): q = s >> 1;
      DB'(3): q = p[PW-1:K];
      DB'(4): q = s >> 2;
      default: q = '0;
    endcase
    return q;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        quot_a <= avg(num_a, den_a);
        quot_b <= avg(num_b, den_b);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/grid_hole_fill_neighbour_average.sv
// ----------------------------------------------------------------------------
// grid_hole_fill_neighbour_average
// Per-module gain / time constant grids with neighbour-average hole filling.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------
//   in      | in_valid, in_ready  | req_type module_req col row gain_in rc_in
//   out     | out_valid, out_ready| gain_out rc_out holes_filled holes_left
//
// Cell write / read: one RAM access between accept and result.
// Fill: each cell scanned is read and checked; a hole cell then reads its
//   in-grid neighbours, averages them in the divider and writes back.
// After reset a clearing pass writes zero to every RAM word,
//   NUM_MODULES*GRID_COLS*GRID_ROWS words (36864 at defaults); no item taken.
// One item at a time; a waiting result only stalls the block at its end.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_hole_fill_neighbour_average #(
  parameter int GRID_COLS   = ghfna_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS   = ghfna_pkg::GRID_ROWS_DEF,
  parameter int NUM_MODULES = ghfna_pkg::NUM_MODULES_DEF,
  parameter int VALUE_BITS  = ghfna_pkg::VALUE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [4:0]  module_req,
  input  wire logic [5:0]  col,
  input  wire logic [4:0]  row,
  input  wire logic [23:0] gain_in,
  input  wire logic [23:0] rc_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [ghfna_pkg::OUT_BITS-1:0]   gain_out,
  output logic [ghfna_pkg::OUT_BITS-1:0]   rc_out,
  output logic [ghfna_pkg::COUNT_BITS-1:0] holes_filled,
  output logic [ghfna_pkg::COUNT_BITS-1:0] holes_left
);

  localparam int CELLS  = GRID_COLS * GRID_ROWS;
  localparam int DEPTH  = NUM_MODULES * CELLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WORD_W = 2 * VALUE_BITS;
  localparam int SUM_W  = VALUE_BITS + 2;
  localparam int X_W    = $clog2(GRID_COLS);
  localparam int Y_W    = $clog2(GRID_ROWS);
  localparam int DB     = ghfna_pkg::DIV_BITS;

  typedef enum logic [9:0] {
    ST_CLEAR    = 10'b00_0000_0001,
    ST_IDLE     = 10'b00_0000_0010,
    ST_RESULT   = 10'b00_0000_0100,
    ST_SCAN_RD  = 10'b00_0000_1000,
    ST_SCAN_CHK = 10'b00_0001_0000,
    ST_NB_RD    = 10'b00_0010_0000,
    ST_NB_ACC   = 10'b00_0100_0000,
    ST_DIV_GO   = 10'b00_1000_0000,
    ST_DIV_WAIT = 10'b01_0000_0000,
    ST_WB       = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic              accept;
  logic              mod_ok;
  logic              port_ok;
  logic [ADDR_W-1:0] mod_base;
  logic [ADDR_W-1:0] port_addr;

  logic [ADDR_W-1:0] addr;
  logic [X_W-1:0]    x;
  logic [Y_W-1:0]    y;
  logic [1:0]        nb;
  logic              nb_ok;
  logic [ADDR_W-1:0] nb_addr;
  logic              last_cell;
  logic              adv;

  logic [1:0]        req_kind;
  logic              req_ok;

  logic [VALUE_BITS-1:0] ctr_g;
  logic [VALUE_BITS-1:0] ctr_r;
  logic                  hole_g;
  logic                  hole_r;
  logic [SUM_W-1:0]      sum_g;
  logic [SUM_W-1:0]      sum_r;
  logic [DB-1:0]         n_g;
  logic [DB-1:0]         n_r;
  logic                  fill_g;
  logic                  fill_r;
  logic                  any_hole;

  logic [ghfna_pkg::COUNT_BITS-1:0] cnt_filled;
  logic [ghfna_pkg::COUNT_BITS-1:0] cnt_left;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [VALUE_BITS-1:0] rd_g;
  logic [VALUE_BITS-1:0] rd_r;

  logic              div_done;
  logic [SUM_W-1:0]  q_g;
  logic [SUM_W-1:0]  q_r;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign mod_ok   = 32'(module_req) < NUM_MODULES;
  assign port_ok  = mod_ok && (32'(col) < GRID_COLS) && (32'(row) < GRID_ROWS);
  assign mod_base = ADDR_W'(module_req) * ADDR_W'(CELLS);
  assign port_addr = mod_base + ADDR_W'(row) * ADDR_W'(GRID_COLS) + ADDR_W'(col);

  assign rd_g = ram_rdata[WORD_W-1:VALUE_BITS];
  assign rd_r = ram_rdata[VALUE_BITS-1:0];

  assign any_hole  = (rd_g == '0) || (rd_r == '0);
  assign last_cell = (x == X_W'(GRID_COLS - 1)) && (y == Y_W'(GRID_ROWS - 1));
  assign adv       = ((state == ST_SCAN_CHK) && !any_hole) || (state == ST_WB);
  assign fill_g    = hole_g && (n_g != '0);
  assign fill_r    = hole_r && (n_r != '0);

  // neighbours: left, right, above, below
  always_comb begin
    nb_ok   = 1'b0;
    nb_addr = addr;
    unique case (nb)
      2'd0: begin
        nb_ok   = x != '0;
        nb_addr = addr - ADDR_W'(1);
      end
      2'd1: begin
        nb_ok   = x != X_W'(GRID_COLS - 1);
        nb_addr = addr + ADDR_W'(1);
      end
      2'd2: begin
        nb_ok   = y != '0;
        nb_addr = addr - ADDR_W'(GRID_COLS);
      end
      2'd3: begin
        nb_ok   = y != Y_W'(GRID_ROWS - 1);
        nb_addr = addr + ADDR_W'(GRID_COLS);
      end
    endcase
  end

  // RAM access; reads and writes never share a cycle, so no forwarding
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = addr;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        if (accept && port_ok && (req_type == ghfna_pkg::REQ_WRITE)) begin
          ram_we    = 1'b1;
          ram_waddr = port_addr;
          ram_wdata = {VALUE_BITS'(gain_in), VALUE_BITS'(rc_in)};
        end
        if (accept && port_ok && (req_type == ghfna_pkg::REQ_READ)) begin
          ram_re    = 1'b1;
          ram_raddr = port_addr;
        end
      end
      ST_SCAN_RD: begin
        ram_re = 1'b1;
      end
      ST_NB_RD: begin
        ram_re    = nb_ok;
        ram_raddr = nb_addr;
      end
      ST_WB: begin
        ram_we    = 1'b1;
        ram_wdata = {fill_g ? VALUE_BITS'(q_g) : ctr_g,
                     fill_r ? VALUE_BITS'(q_r) : ctr_r};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (addr == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if ((req_type == ghfna_pkg::REQ_FILL) && mod_ok) state_next = ST_SCAN_RD;
          else state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      ST_SCAN_RD: begin
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (any_hole) state_next = ST_NB_RD;
        else if (last_cell) state_next = ST_RESULT;
        else state_next = ST_SCAN_RD;
      end
      ST_NB_RD: begin
        if (nb_ok) state_next = ST_NB_ACC;
        else if (nb == 2'd3) state_next = ST_DIV_GO;
      end
      ST_NB_ACC: begin
        state_next = (nb == 2'd3) ? ST_DIV_GO : ST_NB_RD;
      end
      ST_DIV_GO: begin
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) state_next = ST_WB;
      end
      ST_WB: begin
        state_next = last_cell ? ST_RESULT : ST_SCAN_RD;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      addr      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && (state != ST_RESULT)) out_valid <= 1'b0;

      unique case (state)
        ST_CLEAR: begin
          addr <= addr + ADDR_W'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            req_kind   <= req_type;
            req_ok     <= port_ok;
            cnt_filled <= '0;
            cnt_left   <= '0;
            addr       <= mod_base;
            x          <= '0;
            y          <= '0;
          end
        end
        ST_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            gain_out     <= '0;
            rc_out       <= '0;
            holes_filled <= cnt_filled;
            holes_left   <= cnt_left;
            if ((req_kind == ghfna_pkg::REQ_READ) && req_ok) begin
              gain_out <= ghfna_pkg::OUT_BITS'(rd_g);
              rc_out   <= ghfna_pkg::OUT_BITS'(rd_r);
            end
          end
        end
        ST_SCAN_CHK: begin
          ctr_g  <= rd_g;
          ctr_r  <= rd_r;
          hole_g <= rd_g == '0;
          hole_r <= rd_r == '0;
          sum_g  <= '0;
          sum_r  <= '0;
          n_g    <= '0;
          n_r    <= '0;
          nb     <= '0;
        end
        ST_NB_RD: begin
          if (!nb_ok) nb <= nb + 2'd1;
        end
        ST_NB_ACC: begin
          if (rd_g != '0) begin
            sum_g <= sum_g + SUM_W'(rd_g);
            n_g   <= n_g + DB'(1);
          end
          if (rd_r != '0) begin
            sum_r <= sum_r + SUM_W'(rd_r);
            n_r   <= n_r + DB'(1);
          end
          nb <= nb + 2'd1;
        end
        ST_WB: begin
          cnt_filled <= ghfna_pkg::sat_add(cnt_filled,
                                           {1'b0, fill_g} + {1'b0, fill_r});
          cnt_left   <= ghfna_pkg::sat_add(cnt_left,
                                           {1'b0, hole_g && !fill_g} +
                                           {1'b0, hole_r && !fill_r});
        end
        default: begin
        end
      endcase

      if (adv) begin
        addr <= addr + ADDR_W'(1);
        if (x == X_W'(GRID_COLS - 1)) begin
          x <= '0;
          y <= y + Y_W'(1);
        end else begin
          x <= x + X_W'(1);
        end
      end
    end
  end

  ghfna_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ghfna_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (state == ST_DIV_GO),
    .num_a  (sum_g),
    .den_a  (n_g),
    .num_b  (sum_r),
    .den_b  (n_r),
    .done   (div_done),
    .quot_a (q_g),
    .quot_b (q_r)
  );

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !ram_re)
    else $error("RAM read and write in the same cycle");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second item taken while one is in work");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_acc_after_read: assert property (@(posedge clk) disable iff (rst)
    state == ST_NB_ACC |-> $past(ram_re))
    else $error("neighbour accumulated without a read");

  a_wb_hole: assert property (@(posedge clk) disable iff (rst)
    state == ST_WB |-> (hole_g || hole_r))
    else $error("write back of a cell without a hole");

endmodule

`default_nettype wire
